// ===== sv/v3n_pkg.sv =====
// shared constants for the vector normalisation block
package v3n_pkg;

	localparam int unsigned COMP_W  = 32;
	localparam int unsigned TOL_W   = 16;
	localparam int unsigned SUM_W   = 64;
	localparam int unsigned REM_W   = 34;
	localparam int unsigned QUO_W   = 31;
	localparam int unsigned SQRT_ST = 32;
	localparam int unsigned DIV_ST  = 31;
	localparam logic [COMP_W-1:0] ONE_Q30 = 32'h4000_0000;
	localparam logic [TOL_W-1:0]  TOL_RESET = 16'd7;

endpackage

// ===== sv/vector3_normalize.sv =====
// vector normalisation pipeline: magnitude and unit vector of a Q16.16 3-vector
//
// Input channel: in_valid/in_stall with x_in, y_in, z_in (signed Q16.16).
// Output channel: out_valid/out_stall with x_unit, y_unit, z_unit (signed
// Q1.30), magnitude (unsigned Q16.16) and degenerate.
// Config: tol_wr_en/tol_wr_data write the tolerance register (reset 7); write
// it only while no request is in flight.
// Throughput: one request per cycle while no valid result is stalled. A request passes the
// abs, square and sum stages, the 32-step square root, the compare stage, the 31-step
// divider (each one register stage per result bit) and the output stage to out_valid.
// The whole pipeline advances as one; when the receiver stalls a valid
// result, every stage holds and in_stall rises, so nothing is lost or repeated.
// Empty stages are not compressed during a stall.
// Reset (arst_n low) clears every stage valid bit and loads the tolerance
// with 7; payload registers are not reset.
module vector3_normalize import v3n_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic signed [COMP_W-1:0] x_in,
	input  logic signed [COMP_W-1:0] y_in,
	input  logic signed [COMP_W-1:0] z_in,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic signed [COMP_W-1:0] x_unit,
	output logic signed [COMP_W-1:0] y_unit,
	output logic signed [COMP_W-1:0] z_unit,
	output logic        [COMP_W-1:0] magnitude,
	output logic                     degenerate,
	input  logic                     tol_wr_en,
	input  logic        [TOL_W-1:0]  tol_wr_data
);

	logic             ce;
	logic [TOL_W-1:0] tol_q;

	// front stages
	logic              v_s1, v_s2, v_s3;
	logic [2:0]        neg_s1, neg_s2, neg_s3;
	logic [COMP_W-1:0] a_s1 [3];
	logic [COMP_W-1:0] a_s2 [3];
	logic [COMP_W-1:0] a_s3 [3];
	logic [SUM_W-1:0]  sq_s2 [3];
	logic [SUM_W-1:0]  sum_s3;

	// square root stages
	logic              sv   [SQRT_ST+1];
	logic [2:0]        sneg [SQRT_ST+1];
	logic [COMP_W-1:0] sa   [SQRT_ST+1][3];
	logic [SUM_W-1:0]  srad [SQRT_ST+1];
	logic [REM_W-1:0]  srem [SQRT_ST+1];
	logic [COMP_W-1:0] sroot[SQRT_ST+1];

	// compare stage
	logic              v_s4;
	logic [2:0]        neg_s4;
	logic [COMP_W-1:0] a_s4 [3];
	logic [COMP_W-1:0] mag_s4;
	logic              dg_s4;

	// divider stages
	logic              dv   [DIV_ST+1];
	logic [2:0]        dneg [DIV_ST+1];
	logic [COMP_W-1:0] da   [DIV_ST+1][3];
	logic [COMP_W:0]   drem [DIV_ST+1][3];
	logic [QUO_W-1:0]  dquo [DIV_ST+1][3];
	logic [COMP_W-1:0] dmag [DIV_ST+1];
	logic              ddg  [DIV_ST+1];

	// output stage
	logic              v_s5;
	logic [COMP_W-1:0] u_s5 [3];
	logic [COMP_W-1:0] mag_s5;
	logic              dg_s5;

	assign ce       = !(v_s5 && out_stall);
	assign in_stall = !ce;

	// tolerance register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= TOL_RESET;
		end else if (tol_wr_en) begin
			tol_q <= tol_wr_data;
		end
	end

	// valid bits of the front stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (ce) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// absolute values, squares, sum of squares
	always_ff @(posedge clk) begin
		if (ce) begin
			neg_s1 <= {z_in[COMP_W-1], y_in[COMP_W-1], x_in[COMP_W-1]};
			a_s1[0] <= x_in[COMP_W-1] ? COMP_W'(-x_in) : COMP_W'(x_in);
			a_s1[1] <= y_in[COMP_W-1] ? COMP_W'(-y_in) : COMP_W'(y_in);
			a_s1[2] <= z_in[COMP_W-1] ? COMP_W'(-z_in) : COMP_W'(z_in);
			neg_s2 <= neg_s1;
			neg_s3 <= neg_s2;
			for (int i = 0; i < 3; i++) begin
				a_s2[i]  <= a_s1[i];
				sq_s2[i] <= SUM_W'(a_s1[i]) * SUM_W'(a_s1[i]);
				a_s3[i]  <= a_s2[i];
			end
			sum_s3 <= sq_s2[0] + sq_s2[1] + sq_s2[2];
		end
	end

	// square root entry
	assign sv[0]    = v_s3;
	assign sneg[0]  = neg_s3;
	assign sa[0]    = a_s3;
	assign srad[0]  = sum_s3;
	assign srem[0]  = '0;
	assign sroot[0] = '0;

	// one root bit per stage
	for (genvar k = 0; k < SQRT_ST; k++) begin : g_sqrt
		logic [REM_W+1:0] sh;
		logic [REM_W+1:0] trial;
		logic             take;
		assign sh    = {srem[k], srad[k][SUM_W-1 -: 2]};
		assign trial = {2'b00, sroot[k], 2'b01};
		assign take  = sh >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sv[k+1] <= 1'b0;
			end else if (ce) begin
				sv[k+1] <= sv[k];
			end
		end

		always_ff @(posedge clk) begin
			if (ce) begin
				sneg[k+1]  <= sneg[k];
				sa[k+1]    <= sa[k];
				srad[k+1]  <= {srad[k][SUM_W-3:0], 2'b00};
				srem[k+1]  <= take ? REM_W'(sh - trial) : REM_W'(sh);
				sroot[k+1] <= {sroot[k][COMP_W-2:0], take};
			end
		end
	end

	// degenerate compare
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (ce) begin
			v_s4 <= sv[SQRT_ST];
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			neg_s4 <= sneg[SQRT_ST];
			a_s4   <= sa[SQRT_ST];
			mag_s4 <= sroot[SQRT_ST];
			dg_s4  <= sroot[SQRT_ST] <= COMP_W'(tol_q);
		end
	end

	// divider entry
	assign dv[0]   = v_s4;
	assign dneg[0] = neg_s4;
	assign da[0]   = a_s4;
	assign dmag[0] = mag_s4;
	assign ddg[0]  = dg_s4;
	for (genvar i = 0; i < 3; i++) begin : g_dent
		assign drem[0][i] = {1'b0, a_s4[i]};
		assign dquo[0][i] = '0;
	end

	// one quotient bit per stage, three lanes
	for (genvar j = 0; j < DIV_ST; j++) begin : g_div
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv[j+1] <= 1'b0;
			end else if (ce) begin
				dv[j+1] <= dv[j];
			end
		end

		always_ff @(posedge clk) begin
			if (ce) begin
				dneg[j+1] <= dneg[j];
				da[j+1]   <= da[j];
				dmag[j+1] <= dmag[j];
				ddg[j+1]  <= ddg[j];
			end
		end

		for (genvar i = 0; i < 3; i++) begin : g_lane
			logic [COMP_W:0] rt;
			logic            take;
			assign rt   = (j == 0) ? drem[j][i] : {drem[j][i][COMP_W-1:0], 1'b0};
			assign take = rt >= {1'b0, dmag[j]};

			always_ff @(posedge clk) begin
				if (ce) begin
					drem[j+1][i] <= take ? (rt - {1'b0, dmag[j]}) : rt;
					dquo[j+1][i] <= {dquo[j][i][QUO_W-2:0], take};
				end
			end
		end
	end

	// clamp, flush and sign
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (ce) begin
			v_s5 <= dv[DIV_ST];
		end
	end

	always_ff @(posedge clk) begin
		logic [COMP_W-1:0] q;
		logic [COMP_W-1:0] lim;
		if (ce) begin
			lim = {2'b00, tol_q, 14'd0};
			for (int i = 0; i < 3; i++) begin
				if (ddg[DIV_ST]) begin
					q = (da[DIV_ST][i] > 32'h0001_0000) ? ONE_Q30
						: {da[DIV_ST][i][17:0], 14'd0};
				end else begin
					q = (COMP_W'(dquo[DIV_ST][i]) > ONE_Q30) ? ONE_Q30
						: COMP_W'(dquo[DIV_ST][i]);
				end
				if (q < lim) begin
					q = '0;
				end
				u_s5[i] <= dneg[DIV_ST][i] ? (~q + 1'b1) : q;
			end
			mag_s5 <= dmag[DIV_ST];
			dg_s5  <= ddg[DIV_ST];
		end
	end

	assign out_valid  = v_s5;
	assign x_unit     = u_s5[0];
	assign y_unit     = u_s5[1];
	assign z_unit     = u_s5[2];
	assign magnitude  = mag_s5;
	assign degenerate = dg_s5;

endmodule

// ===== sv/v3n_checker.sv =====
// port-level checks for the vector normalisation block
module v3n_checker import v3n_pkg::*; (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     in_stall,
	input logic                     out_valid,
	input logic                     out_stall,
	input logic signed [COMP_W-1:0] x_unit,
	input logic        [COMP_W-1:0] magnitude,
	input logic                     degenerate
);

	// a stalled result is held
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(x_unit) && $stable(magnitude))
		else $error("stalled result changed");

	// input side stalls exactly when a result is stuck
	a_back: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall == (out_valid && out_stall))
		else $error("input stall does not follow output stall");

	// unit components stay within plus or minus one
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (x_unit <= $signed(ONE_Q30)) && (x_unit >= -$signed(ONE_Q30)))
		else $error("unit component out of range");

	// zero length is always degenerate
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (magnitude == '0) |-> degenerate)
		else $error("zero vector not flagged");

endmodule

bind vector3_normalize v3n_checker u_v3n_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_stall   (in_stall),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.x_unit     (x_unit),
	.magnitude  (magnitude),
	.degenerate (degenerate)
);
